// ===== design/variable_width_bit_packer_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the variable-width bit packer
// Shared property forms used by the design modules.
// ----------------------------------------------------------------------------
`ifndef VARIABLE_WIDTH_BIT_PACKER_MACROS_SVH
`define VARIABLE_WIDTH_BIT_PACKER_MACROS_SVH

// condition holds at every edge out of reset
`define VWBP_ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("vwbp: invariant violated");

// consequent holds in the same cycle
`define VWBP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("vwbp: same-cycle check failed");

// consequent holds in the next cycle
`define VWBP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("vwbp: next-cycle check failed");

`endif

// ===== design/vwbp_pkg.sv =====
// ----------------------------------------------------------------------------
// vwbp_pkg
// Types and constants shared by the bit packer modules.
// ----------------------------------------------------------------------------
package vwbp_pkg;

	localparam int unsigned WORD_BITS  = 32;
	localparam int unsigned BLOCK_BITS = 31;
	localparam int unsigned WIDTH_BITS = 5;
	localparam int unsigned FILL_BITS  = 5;

	localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = 5'd8;

	typedef struct packed {
		logic [WORD_BITS-1:0] word;
		logic                 last;
	} result_t;

	typedef struct packed {
		logic [1:0] count;
		result_t    r0;
		result_t    r1;
	} push_t;

endpackage

// ===== design/vwbp_core.sv =====
// ----------------------------------------------------------------------------
// vwbp_core
// Input register, block width register, accumulator and fill count; forms
// up to two packed words per block.
// ----------------------------------------------------------------------------
`include "variable_width_bit_packer_macros.svh"

module vwbp_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [vwbp_pkg::WIDTH_BITS-1:0]      cfg_wdata,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [vwbp_pkg::BLOCK_BITS-1:0]      in_data,
	input  logic                                 in_last,
	input  logic [1:0]                           free,
	output vwbp_pkg::push_t                      push
);

	logic [vwbp_pkg::WIDTH_BITS-1:0] width_q;
	logic                            valid_s1;
	logic [vwbp_pkg::BLOCK_BITS-1:0] data_s1;
	logic                            last_s1;
	logic [vwbp_pkg::WORD_BITS-1:0]  acc_q;
	logic [vwbp_pkg::FILL_BITS-1:0]  fill_q;

	logic [vwbp_pkg::BLOCK_BITS-1:0] v_m;
	logic [62:0]                     combined;
	logic [5:0]                      total;
	logic                            full;
	logic [4:0]                      rest;
	logic [1:0]                      n;
	logic                            s1_adv;
	vwbp_pkg::result_t               r0;
	vwbp_pkg::result_t               r1;
	logic [vwbp_pkg::WORD_BITS-1:0]  acc_n;
	logic [vwbp_pkg::FILL_BITS-1:0]  fill_n;

	always_comb begin
		v_m      = data_s1 & ~({vwbp_pkg::BLOCK_BITS{1'b1}} << width_q);
		combined = {31'b0, acc_q} | ({32'b0, v_m} << fill_q);
		total    = {1'b0, fill_q} + {1'b0, width_q};
		full     = total[5];
		rest     = total[4:0];
		r0.word  = combined[31:0];
		r0.last  = 1'b0;
		r1.word  = {1'b0, combined[62:32]};
		r1.last  = 1'b1;
		n        = 2'd0;
		if (full) begin
			n       = 2'd1;
			r0.last = last_s1 && (rest == 5'd0);
			if (last_s1 && (rest != 5'd0)) begin
				n = 2'd2;
			end
		end else if (last_s1) begin
			n       = 2'd1;
			r0.last = 1'b1;
		end
		if (last_s1) begin
			acc_n  = '0;
			fill_n = '0;
		end else if (full) begin
			acc_n  = {1'b0, combined[62:32]};
			fill_n = rest;
		end else begin
			acc_n  = combined[31:0];
			fill_n = total[4:0];
		end
	end

	assign s1_adv     = valid_s1 && (n <= free);
	assign in_ready   = !valid_s1 || s1_adv;
	assign push.count = s1_adv ? n : 2'd0;
	assign push.r0    = r0;
	assign push.r1    = r1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= vwbp_pkg::WIDTH_RESET;
		end else if (cfg_we) begin
			width_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= in_data;
			last_s1 <= in_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			fill_q <= '0;
		end else if (s1_adv) begin
			acc_q  <= acc_n;
			fill_q <= fill_n;
		end
	end

	`VWBP_ASSERT_NEXT(a_final_clears, clk, arst_n, s1_adv && last_s1, (acc_q == '0) && (fill_q == '0))
	`VWBP_ASSERT_ALWAYS(a_acc_above_fill_zero, clk, arst_n, (acc_q >> fill_q) == '0)
	`VWBP_ASSERT_NEXT(a_stall_holds_item, clk, arst_n, valid_s1 && !s1_adv, valid_s1)

endmodule

// ===== design/vwbp_out_queue.sv =====
// ----------------------------------------------------------------------------
// vwbp_out_queue
// Two-entry result queue; the head entry drives the output channel.
// ----------------------------------------------------------------------------
`include "variable_width_bit_packer_macros.svh"

module vwbp_out_queue (
	input  logic                            clk,
	input  logic                            arst_n,
	input  vwbp_pkg::push_t                 push,
	output logic [1:0]                      free,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [vwbp_pkg::WORD_BITS-1:0]  out_word,
	output logic                            out_last
);

	logic [1:0]        cnt_q;
	vwbp_pkg::result_t q0_q;
	vwbp_pkg::result_t q1_q;

	logic              pop;
	logic [1:0]        cnt_ap;
	logic [1:0]        cnt_n;
	vwbp_pkg::result_t q0_n;
	vwbp_pkg::result_t q1_n;

	assign out_valid = (cnt_q != 2'd0);
	assign pop       = out_valid && out_ready;
	assign cnt_ap    = cnt_q - {1'b0, pop};
	assign free      = 2'd2 - cnt_ap;
	assign cnt_n     = cnt_ap + push.count;
	assign out_word  = q0_q.word;
	assign out_last  = q0_q.last;

	always_comb begin
		q0_n = pop ? q1_q : q0_q;
		q1_n = q1_q;
		case (cnt_ap)
			2'd0: begin
				q0_n = push.r0;
				q1_n = push.r1;
			end
			2'd1: begin
				q1_n = push.r0;
			end
			default: begin
				q1_n = q1_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_n;
		end
	end

	always_ff @(posedge clk) begin
		q0_q <= q0_n;
		q1_q <= q1_n;
	end

	`VWBP_ASSERT_ALWAYS(a_push_fits, clk, arst_n, push.count <= free)
	`VWBP_ASSERT_NEXT(a_pop_drains, clk, arst_n, pop && (push.count == 2'd0), cnt_q == $past(cnt_q) - 2'd1)
	`VWBP_ASSERT_NEXT(a_push_shows, clk, arst_n, (push.count != 2'd0) && (cnt_ap == 2'd0), out_valid)

endmodule

// ===== design/variable_width_bit_packer.sv =====
// ----------------------------------------------------------------------------
// variable_width_bit_packer
// Packs blocks of a configured width, LSB first, into 32-bit words.
// ----------------------------------------------------------------------------
// channel   direction  payload (low bit up)              handshake
// s_axis    in         tdata: block_value[30:0], pad 0    tvalid/tready
//                      tlast: final_block
// m_axis    out        tdata: packed_word[31:0]           tvalid/tready
//                      tlast: last_word
// cfg       in         cfg_wdata: block_width[4:0]        cfg_we
//
// One block per cycle while the result queue has room; a block yields 0, 1
// or 2 words, and one word leaves per cycle while m_axis_tready is high.
// A block passes through the input register and then the result queue.
// The two-entry result queue sets how far the input runs ahead of a stall.
// Reset: block_width 8, accumulator and fill count cleared, queue empty.
// ----------------------------------------------------------------------------
module variable_width_bit_packer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [4:0]  cfg_wdata,      // block_width[4:0]
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // block_value[30:0], zero [31]
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // packed_word[31:0]
	output logic        m_axis_tlast
);

	vwbp_pkg::push_t push;
	logic [1:0]      free;

	vwbp_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_data  (s_axis_tdata[30:0]),
		.in_last  (s_axis_tlast),
		.free     (free),
		.push     (push)
	);

	vwbp_out_queue u_out_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.free     (free),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_word (m_axis_tdata),
		.out_last (m_axis_tlast)
	);

endmodule

// ===== verif/variable_width_bit_packer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// variable_width_bit_packer_tb
// Drives blocks of fixed and random widths through the packer and compares
// each output word and last flag with the bench's behavioral packing model.
// ----------------------------------------------------------------------------
module variable_width_bit_packer_tb;

	localparam int IDLE_LIMIT   = 4000;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 8;
	localparam int MAX_WAIT     = 16;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [4:0]  cfg_wdata;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;
	logic        m_axis_tlast;

	vwbp_pkg::result_t expected_words[$];
	logic [4:0]  width_cfg;
	logic [31:0] acc_bits;
	logic [4:0]  fill_bits;
	int          send_gap_max;
	int          recv_gap_max;
	int          hold_request;
	int          mismatches;
	int          idle_cycles;

	variable_width_bit_packer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	function automatic int draw_wait(input int max_wait);
		if (max_wait == 0) return 0;
		return $urandom_range(max_wait, 0);
	endfunction

	function automatic logic [30:0] draw_block();
		logic [31:0] raw;
		raw = $urandom();
		case ($urandom_range(7, 0))
			0: return '0;
			1: return '1;
			2: return raw[30:0] & 31'h0000_00FF;
			default: return raw[30:0];
		endcase
	endfunction

	function automatic void pack_block(input logic [30:0] value, input logic fin);
		logic [63:0]       keep;
		logic [63:0]       combined;
		logic [5:0]        total;
		vwbp_pkg::result_t r;
		int                n;
		keep = (64'd1 << width_cfg) - 64'd1;
		combined = ({32'd0, acc_bits} & ((64'd1 << fill_bits) - 64'd1))
			| (({33'd0, value} & keep) << fill_bits);
		total = {1'b0, fill_bits} + {1'b0, width_cfg};
		n = 0;
		if (total >= vwbp_pkg::WORD_BITS) begin
			r.word = combined[31:0];
			r.last = fin && (total == vwbp_pkg::WORD_BITS);
			expected_words.push_back(r);
			combined = combined >> vwbp_pkg::WORD_BITS;
			total = total - 6'(vwbp_pkg::WORD_BITS);
			n = 1;
		end
		if (fin) begin
			if (total != 0) begin
				r.word = combined[31:0];
				r.last = 1'b1;
				expected_words.push_back(r);
			end else if (n == 0) begin
				r.word = '0;
				r.last = 1'b1;
				expected_words.push_back(r);
			end
			acc_bits = '0;
			fill_bits = '0;
		end else begin
			acc_bits = combined[31:0];
			fill_bits = total[4:0];
		end
	endfunction

	task automatic note_mismatch(input vwbp_pkg::result_t want, input vwbp_pkg::result_t got,
		input bit orphan);
		mismatches++;
		if (mismatches <= 10) begin
			if (orphan)
				$display("mismatch: word %h last %b with none expected", got.word, got.last);
			else
				$display("mismatch: expected word %h last %b, got word %h last %b",
					want.word, want.last, got.word, got.last);
		end
	endtask

	task automatic check_word(input vwbp_pkg::result_t got);
		vwbp_pkg::result_t want;
		want = '0;
		if (expected_words.size() == 0) begin
			note_mismatch(want, got, 1'b1);
		end else begin
			want = expected_words.pop_front();
			if (got.word !== want.word || got.last !== want.last)
				note_mismatch(want, got, 1'b0);
		end
	endtask

	task automatic send_block(input logic [30:0] value, input logic fin);
		int   gap;
		logic ready;
		gap = draw_wait(send_gap_max);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {1'b0, value};
		s_axis_tlast  <= fin;
		do begin
			@(negedge clk);
			ready = s_axis_tready;
			if (ready) pack_block(value, fin);
			@(posedge clk);
		end while (!ready);
	endtask

	// drop valid, wait for every word, then let the pipeline empty
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_width(input logic [4:0] w);
		settle();
		cfg_we    <= 1'b1;
		cfg_wdata <= w;
		@(posedge clk);
		cfg_we    <= 1'b0;
		width_cfg = w;
	endtask

	task automatic test_reset_width();
		send_gap_max = 0;
		recv_gap_max = 0;
		send_block(31'h7FFF_FFFF, 1'b0);
		send_block(31'h0, 1'b0);
		send_block(31'h55, 1'b0);
		send_block(31'hAA, 1'b0);
		send_block(31'h12, 1'b1);
		send_block(31'h1234_5601, 1'b0);
		send_block(31'h02, 1'b0);
		send_block(31'h03, 1'b0);
		send_block(31'h04, 1'b1);
	endtask

	task automatic test_widest_blocks();
		send_gap_max = 3;
		recv_gap_max = 3;
		set_width(5'd31);
		send_block(31'h7FFF_FFFF, 1'b0);
		send_block(31'h2AAA_AAAA, 1'b1);
		send_block(31'h0, 1'b0);
		send_block(31'h5555_5555, 1'b1);
	endtask

	task automatic test_narrow_blocks();
		set_width(5'd1);
		send_block(31'h7FFF_FFFE, 1'b0);
		send_block(31'h1, 1'b0);
		send_block(31'h1, 1'b1);
	endtask

	task automatic test_zero_width();
		set_width(5'd5);
		send_block(31'h1F, 1'b0);
		send_block(31'h0, 1'b0);
		send_block(31'h15, 1'b0);
		// pending bits survive the width change and flush on the final block
		set_width(5'd0);
		send_block(31'h7FFF_FFFF, 1'b0);
		send_block(31'h1, 1'b1);
		send_block(31'h0, 1'b1);
	endtask

	task automatic test_output_stall();
		set_width(5'd31);
		send_gap_max = 0;
		recv_gap_max = 0;
		hold_request = HOLD_CYCLES;
		for (int i = 0; i < 40; i++)
			send_block(draw_block(), ($urandom_range(5, 0) == 0));
		settle();
	endtask

	task automatic test_random_lists();
		logic [4:0] w;
		for (int p = 0; p < 30; p++) begin
			case (p % 6)
				0: w = 5'd31;
				1: w = 5'd1;
				2: w = (p == 2) ? 5'd0 : 5'($urandom_range(31, 0));
				default: w = 5'($urandom_range(31, 0));
			endcase
			set_width(w);
			case (p % 3)
				0: begin
					send_gap_max = 0;
					recv_gap_max = 0;
				end
				1: begin
					send_gap_max = MAX_WAIT;
					recv_gap_max = MAX_WAIT;
				end
				default: begin
					send_gap_max = $urandom_range(MAX_WAIT, 0);
					recv_gap_max = $urandom_range(MAX_WAIT, 0);
				end
			endcase
			for (int i = 0; i < 53; i++) begin
				send_block(draw_block(), ($urandom_range(7, 0) == 0));
				if (i == 26 && p % 5 == 0) settle();
			end
		end
	endtask

	initial begin
		int                gap;
		logic              seen;
		vwbp_pkg::result_t got;
		m_axis_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = (hold_request > 0) ? hold_request : draw_wait(recv_gap_max);
			hold_request = 0;
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do begin
				@(negedge clk);
				seen = m_axis_tvalid;
				got.word = m_axis_tdata;
				got.last = m_axis_tlast;
				@(posedge clk);
			end while (!seen);
			check_word(got);
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles = 0;
			else
				idle_cycles = idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	initial begin
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_wdata     = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		width_cfg     = vwbp_pkg::WIDTH_RESET;
		acc_bits      = '0;
		fill_bits     = '0;
		send_gap_max  = 0;
		recv_gap_max  = 0;
		hold_request  = 0;
		mismatches    = 0;
		idle_cycles   = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_width();
		test_widest_blocks();
		test_narrow_blocks();
		test_zero_width();
		test_output_stall();
		test_random_lists();
		settle();
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
